[sv/ffrp_pkg.sv]
// ----------------------------------------------------------------------------
// ffrp_pkg
// Shared constants and types of the first-fit rectangle placer.
// ----------------------------------------------------------------------------
package ffrp_pkg;

    localparam int ATLAS_SIZE  = 256;
    localparam int COORD_W     = $clog2(ATLAS_SIZE);
    localparam int CNT_W       = COORD_W + 1;
    localparam int STEP_N      = CNT_W;
    localparam int STEP_W      = $clog2(STEP_N);
    localparam int VEC_W       = ATLAS_SIZE + 1;

    localparam int RECT_W      = 9;
    localparam int SPACING_W   = 4;
    localparam int ORIGIN_W    = 8;
    localparam int SIZE_W      = (RECT_W + 1 > CNT_W) ? RECT_W + 1 : CNT_W;

    localparam int IN_TDATA_W  = ((2 * RECT_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + 2 * ORIGIN_W + 7) / 8) * 8;

    typedef logic [ATLAS_SIZE-1:0] row_vec_t;

    typedef struct packed {
        logic               rd_en;
        logic [COORD_W-1:0] rd_addr;
        logic               wr_en;
        logic [COORD_W-1:0] wr_addr;
    } occ_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               found;
        logic [COORD_W-1:0] x;
    } fnd_stat_t;

endpackage

[sv/ffrp_occ_mem.sv]
// ----------------------------------------------------------------------------
// ffrp_occ_mem
// Occupancy map: one row word per atlas row, one read and one write port,
// registered read data. A row never written reads as all free.
// ----------------------------------------------------------------------------
module ffrp_occ_mem import ffrp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  occ_req_t req,
    input  row_vec_t wr_data,
    output row_vec_t rd_data
);

    row_vec_t                occ_mem [ATLAS_SIZE];
    row_vec_t                rd_word_reg;
    logic [ATLAS_SIZE-1:0]   row_valid_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            occ_mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en) begin
            rd_word_reg <= occ_mem[req.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (req.wr_en) begin
                row_valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= row_valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

[sv/ffrp_col_height.sv]
// ----------------------------------------------------------------------------
// ffrp_col_height
// Per-column count of free cells ending at the current row, and the flag
// for each column that the count covers the requested height.
// ----------------------------------------------------------------------------
module ffrp_col_height import ffrp_pkg::*; (
    input  logic             aclk,
    input  logic             clear,
    input  logic             update,
    input  row_vec_t         occ_row,
    input  logic [CNT_W-1:0] need_h,
    output logic [VEC_W-1:0] ok_vec
);

    logic [CNT_W-1:0] height_reg [ATLAS_SIZE];

    always_ff @(posedge aclk) begin
        for (int c = 0; c < ATLAS_SIZE; c++) begin
            if (clear) begin
                height_reg[c] <= '0;
            end else if (update) begin
                if (occ_row[c]) begin
                    height_reg[c] <= '0;
                end else if (height_reg[c] != CNT_W'(ATLAS_SIZE)) begin
                    height_reg[c] <= height_reg[c] + CNT_W'(1);
                end
            end
        end
    end

    // top bit stays low: no window may start past the right edge
    always_comb begin
        ok_vec = '0;
        for (int c = 0; c < ATLAS_SIZE; c++) begin
            ok_vec[c] = (height_reg[c] >= need_h);
        end
    end

endmodule

[sv/ffrp_run_find.sv]
// ----------------------------------------------------------------------------
// ffrp_run_find
// Finds the leftmost column that starts a run of run_len set flags.
// Builds the run window by binary doubling, one bit of run_len per cycle,
// then priority-encodes the surviving start columns.
// ----------------------------------------------------------------------------
module ffrp_run_find import ffrp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VEC_W-1:0] ok_vec,
    input  logic [CNT_W-1:0] run_len,
    output fnd_stat_t        stat
);

    typedef enum logic [1:0] {F_IDLE, F_STEP, F_ENC} fstate_t;

    fstate_t             state_reg, state_next;
    logic [VEC_W-1:0]    pref_reg, pref_next;
    logic [VEC_W-1:0]    win_reg, win_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic                found_reg, found_next;
    logic                done_reg, done_next;
    logic [COORD_W-1:0]  x_reg, x_next;
    logic [VEC_W-1:0]    pref_sh, win_sh;
    logic                hit;
    logic [COORD_W-1:0]  hit_x;

    always_comb begin
        pref_sh = '0;
        win_sh  = '0;
        for (int j = 0; j < STEP_N; j++) begin
            if (step_reg == STEP_W'(j)) begin
                pref_sh = pref_reg >> (1 << j);
                win_sh  = win_reg >> (1 << j);
            end
        end
    end

    always_comb begin
        hit   = 1'b0;
        hit_x = '0;
        for (int c = ATLAS_SIZE - 1; c >= 0; c--) begin
            if (win_reg[c]) begin
                hit   = 1'b1;
                hit_x = COORD_W'(c);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        pref_next  = pref_reg;
        win_next   = win_reg;
        step_next  = step_reg;
        len_next   = len_reg;
        found_next = found_reg;
        x_next     = x_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                if (start) begin
                    pref_next  = ok_vec;
                    win_next   = '1;
                    step_next  = '0;
                    len_next   = run_len;
                    state_next = F_STEP;
                end
            end
            F_STEP: begin
                // append a block of 2^step columns, then double the block
                if (len_reg[step_reg]) begin
                    win_next = pref_reg & win_sh;
                end
                pref_next = pref_reg & pref_sh;
                if (step_reg == STEP_W'(STEP_N - 1)) begin
                    state_next = F_ENC;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            F_ENC: begin
                found_next = hit;
                x_next     = hit_x;
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        pref_reg  <= pref_next;
        win_reg   <= win_next;
        step_reg  <= step_next;
        len_reg   <= len_next;
        found_reg <= found_next;
        x_reg     <= x_next;
    end

    assign stat.busy  = (state_reg != F_IDLE);
    assign stat.done  = done_reg;
    assign stat.found = found_reg;
    assign stat.x     = x_reg;

endmodule

[sv/first_fit_rect_placer.sv]
// ----------------------------------------------------------------------------
// first_fit_rect_placer
// Places padded rectangles first-fit in raster order on a square atlas
// and reserves their cells in the occupancy map.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata fields (low bit first)
//  ----------+-----------+-------------------------------------------------
//  s_        | in        | rect_width[8:0], rect_height[17:9]
//  m_        | out       | placed[0], origin_x[8:1], origin_y[16:9]
//  cfg_wr_   | in        | spacing[3:0]
//
//  Rows are read one at a time; a row below the padded height only updates the
//  column heights, every later row also runs the search (read, column update,
//  9 run-window steps, encode). A hit then reads and writes back each padded
//  row of the map. Reset clears the map at once. A new request is taken while
//  the previous result waits on m_tready.
// ----------------------------------------------------------------------------
module first_fit_rect_placer import ffrp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // rect_width, rect_height
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // placed, origin_x, origin_y
    input  logic                   cfg_wr_en,
    input  logic [SPACING_W-1:0]   cfg_wr_data  // spacing
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_UPD, S_SCAN_CHK, S_SCAN_WAIT,
        S_MARK_RD, S_MARK_WR, S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [SPACING_W-1:0]   spacing_reg;
    logic [RECT_W-1:0]      w_reg, w_next;
    logic [RECT_W-1:0]      h_reg, h_next;
    logic [CNT_W-1:0]       pw_reg, pw_next;
    logic [CNT_W-1:0]       ph_reg, ph_next;
    logic [COORD_W-1:0]     row_reg, row_next;
    logic [COORD_W-1:0]     ox_reg, ox_next;
    logic [COORD_W-1:0]     oy_reg, oy_next;
    logic                   placed_reg, placed_next;
    row_vec_t               mask_reg, mask_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [SIZE_W-1:0]      pw_full, ph_full;
    logic [CNT_W-1:0]       origin_y;
    row_vec_t               mask_calc;
    logic                   last_row;

    occ_req_t               mem_req;
    row_vec_t               mem_wr_data, mem_rd_data;
    logic                   col_clear, col_update;
    logic [VEC_W-1:0]       ok_vec;
    logic                   fnd_start;
    fnd_stat_t              fnd_stat;

    ffrp_occ_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    ffrp_col_height u_col (
        .aclk    (aclk),
        .clear   (col_clear),
        .update  (col_update),
        .occ_row (mem_rd_data),
        .need_h  (ph_reg),
        .ok_vec  (ok_vec)
    );

    ffrp_run_find u_find (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fnd_start),
        .ok_vec  (ok_vec),
        .run_len (pw_reg),
        .stat    (fnd_stat)
    );

    assign pw_full  = SIZE_W'(w_reg) + SIZE_W'(spacing_reg);
    assign ph_full  = SIZE_W'(h_reg) + SIZE_W'(spacing_reg);
    assign origin_y = CNT_W'(row_reg) - (ph_reg - CNT_W'(1));
    assign last_row = (row_reg == COORD_W'(ATLAS_SIZE - 1));

    always_comb begin
        for (int c = 0; c < ATLAS_SIZE; c++) begin
            mask_calc[c] = (CNT_W'(c) >= CNT_W'(fnd_stat.x)) &&
                           ((CNT_W + 1)'(c) <
                            (CNT_W + 1)'(fnd_stat.x) + (CNT_W + 1)'(pw_reg));
        end
    end

    always_comb begin
        state_next   = state_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        pw_next      = pw_reg;
        ph_next      = ph_reg;
        row_next     = row_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        placed_next  = placed_reg;
        mask_next    = mask_reg;
        left_next    = left_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        mem_req      = '0;
        mem_wr_data  = mem_rd_data | mask_reg;
        col_clear    = 1'b0;
        col_update   = 1'b0;
        fnd_start    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    w_next     = s_tdata[RECT_W-1:0];
                    h_next     = s_tdata[2*RECT_W-1:RECT_W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                col_clear = 1'b1;
                if (w_reg == '0 || h_reg == '0 ||
                    pw_full > SIZE_W'(ATLAS_SIZE) || ph_full > SIZE_W'(ATLAS_SIZE)) begin
                    placed_next = 1'b0;
                    ox_next     = '0;
                    oy_next     = '0;
                    state_next  = S_DONE;
                end else begin
                    pw_next    = CNT_W'(pw_full);
                    ph_next    = CNT_W'(ph_full);
                    row_next   = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_reg;
                state_next      = S_SCAN_UPD;
            end
            S_SCAN_UPD: begin
                col_update = 1'b1;
                if (CNT_W'(row_reg) >= ph_reg - CNT_W'(1)) begin
                    state_next = S_SCAN_CHK;
                end else begin
                    row_next   = row_reg + COORD_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_CHK: begin
                fnd_start  = 1'b1;
                state_next = S_SCAN_WAIT;
            end
            S_SCAN_WAIT: begin
                if (fnd_stat.done) begin
                    if (fnd_stat.found) begin
                        ox_next    = fnd_stat.x;
                        oy_next    = COORD_W'(origin_y);
                        row_next   = COORD_W'(origin_y);
                        mask_next  = mask_calc;
                        left_next  = ph_reg;
                        state_next = S_MARK_RD;
                    end else if (last_row) begin
                        placed_next = 1'b0;
                        ox_next     = '0;
                        oy_next     = '0;
                        state_next  = S_DONE;
                    end else begin
                        row_next   = row_reg + COORD_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_MARK_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = row_reg;
                state_next      = S_MARK_WR;
            end
            S_MARK_WR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = row_reg;
                left_next       = left_reg - CNT_W'(1);
                if (left_reg == CNT_W'(1)) begin
                    placed_next = 1'b1;
                    state_next  = S_DONE;
                end else begin
                    row_next   = row_reg + COORD_W'(1);
                    state_next = S_MARK_RD;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_data_next                       = '0;
                    m_data_next[0]                    = placed_reg;
                    m_data_next[ORIGIN_W:1]           = ORIGIN_W'(ox_reg);
                    m_data_next[2*ORIGIN_W:ORIGIN_W+1] = ORIGIN_W'(oy_reg);
                    m_valid_next                      = 1'b1;
                    state_next                        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            spacing_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                spacing_reg <= cfg_wr_data;
            end
        end
        w_reg      <= w_next;
        h_reg      <= h_next;
        pw_reg     <= pw_next;
        ph_reg     <= ph_next;
        row_reg    <= row_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        placed_reg <= placed_next;
        mask_reg   <= mask_next;
        left_reg   <= left_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_fail_zero_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2*ORIGIN_W:1] == '0))
        else $error("refused request carries a nonzero origin");

    a_find_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fnd_start |-> !fnd_stat.busy)
        else $error("run search started while busy");

    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> ($past(mem_req.rd_en) &&
                           ($past(mem_req.rd_addr) == mem_req.wr_addr)))
        else $error("map write without a read of the same row");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit rectangle placer. A scoreboard keeps
// its own occupancy map and spacing, predicts placed/origin for every request
// accepted on s_, and compares each m_ result in order. The stimulus covers
// refused and oversized requests first, then phases of random sizes under
// several spacing settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import ffrp_pkg::*;

    localparam int PHASE_ITEMS = 96;
    localparam int GAP_CYCLES  = 16;
    localparam int DRAIN_CYCLES = 4000;

    typedef struct {
        logic                placed;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
    } placement_t;

    class placement_board;
        row_vec_t   occ [ATLAS_SIZE];
        int         spacing;
        placement_t placements [$];
        int         errors;
        int         n_placed;
        int         n_refused;

        function new();
            foreach (occ[i]) occ[i] = '0;
            spacing   = 0;
            errors    = 0;
            n_placed  = 0;
            n_refused = 0;
        endfunction

        function int pending();
            return placements.size();
        endfunction

        // First fit in raster order: per row, OR the padded height of map rows,
        // then shrink the free mask until each set bit starts a free run of pw.
        function void note_request(logic [RECT_W-1:0] w, logic [RECT_W-1:0] h);
            placement_t res;
            int         pw, ph, y, r, x, run, s;
            row_vec_t   blk, fit, mask;
            bit         found;
            res.placed   = 1'b0;
            res.origin_x = '0;
            res.origin_y = '0;
            pw = int'(w) + spacing;
            ph = int'(h) + spacing;
            found = 1'b0;
            if (w != 0 && h != 0 && pw <= ATLAS_SIZE && ph <= ATLAS_SIZE) begin
                for (y = 0; y + ph <= ATLAS_SIZE && !found; y++) begin
                    blk = '0;
                    for (r = 0; r < ph; r++) blk |= occ[y + r];
                    fit = ~blk;
                    run = 1;
                    while (run < pw) begin
                        s = (run < pw - run) ? run : pw - run;
                        fit &= fit >> s;
                        run += s;
                    end
                    if (fit != '0) begin
                        x = 0;
                        while (!fit[x]) x++;
                        mask = {ATLAS_SIZE{1'b1}};
                        mask = mask >> (ATLAS_SIZE - pw);
                        mask = mask << x;
                        for (r = 0; r < ph; r++) occ[y + r] |= mask;
                        res.placed   = 1'b1;
                        res.origin_x = x[ORIGIN_W-1:0];
                        res.origin_y = y[ORIGIN_W-1:0];
                        found = 1'b1;
                    end
                end
            end
            placements.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            placement_t want;
            if (placements.size() == 0) begin
                $error("result with no request outstanding: tdata=%h", d);
                errors++;
                return;
            end
            want = placements.pop_front();
            if (want.placed) n_placed++;
            else n_refused++;
            if (d[0] !== want.placed) begin
                $error("placed: expected %0d, actual %0d", want.placed, d[0]);
                errors++;
            end
            if (d[ORIGIN_W:1] !== want.origin_x) begin
                $error("origin_x: expected %0d, actual %0d", want.origin_x, d[ORIGIN_W:1]);
                errors++;
            end
            if (d[2*ORIGIN_W:ORIGIN_W+1] !== want.origin_y) begin
                $error("origin_y: expected %0d, actual %0d", want.origin_y,
                       d[2*ORIGIN_W:ORIGIN_W+1]);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // rect_width, rect_height
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // placed, origin_x, origin_y
    logic                   cfg_wr_en;
    logic [SPACING_W-1:0]   cfg_wr_data; // spacing

    placement_board board = new();
    bit calm;

    first_fit_rect_placer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Check results before noting requests of the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if (s_tvalid && s_tready)
                board.note_request(s_tdata[RECT_W-1:0], s_tdata[2*RECT_W-1:RECT_W]);
        end
    end

    // Result side: ready runs and stall bursts, always ready once calm.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                m_tready = 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end else begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
        end
    end

    initial begin
        #100000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_spacing(int value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value[SPACING_W-1:0];
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        board.spacing = value & ((1 << SPACING_W) - 1);
        @(negedge aclk);
    endtask

    // Hold the request until it is taken; leaves s_tvalid high.
    task automatic send_request(int w, int h);
        s_tdata  = '0;
        s_tdata[RECT_W-1:0]        = w[RECT_W-1:0];
        s_tdata[2*RECT_W-1:RECT_W] = h[RECT_W-1:0];
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (GAP_CYCLES) @(negedge aclk);
    endtask

    function automatic int rand_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 16);
        if (r < 90) return $urandom_range(17, 64);
        if (r < 95) return $urandom_range(65, 256);
        if (r < 97) return 0;
        return $urandom_range(257, 511);
    endfunction

    task automatic run_random(int count, bit with_pause);
        int i;
        for (i = 0; i < count; i++) begin
            if (with_pause && i == count / 2) wait_idle();
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            send_request(rand_size(), rand_size());
        end
    endtask

    initial begin
        calm        = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // zero sizes, oversized fields, full row, full column
        write_spacing(0);
        send_request(0, 5);
        send_request(5, 0);
        send_request(0, 0);
        send_request(511, 511);
        send_request(257, 3);
        send_request(3, 257);
        send_request(256, 1);
        send_request(1, 256);
        send_request(1, 255);
        send_request(1, 1);
        send_request(3, 2);
        send_request(255, 1);
        wait_idle();

        // padding pushes an in-range size out of the atlas
        write_spacing(15);
        send_request(242, 1);
        send_request(1, 242);
        send_request(241, 1);
        send_request(1, 1);
        send_request(6, 9);
        send_request(0, 1);
        wait_idle();

        write_spacing(7);
        send_request(4, 4);
        send_request(249, 1);
        send_request(2, 3);
        wait_idle();

        write_spacing(0);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_spacing(15);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_spacing($urandom_range(1, 14));
        run_random(PHASE_ITEMS, 1'b1);
        wait_idle();
        write_spacing(3);
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_spacing($urandom_range(0, 15));
        run_random(PHASE_ITEMS, 1'b0);
        wait_idle();
        write_spacing(0);
        calm = 1'b1;
        run_random(PHASE_ITEMS, 1'b0);

        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d requests: %0d placed, %0d refused or without room.",
                 board.n_placed + board.n_refused, board.n_placed, board.n_refused);
        $display("Spacing settings 0, 3, 7, 15 and random ones; %0d mismatches.",
                 board.errors);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
